### design/rdpd_pkg.sv
`default_nettype none
package rdpd_pkg;

    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int COORD_W    = 12;
    localparam int NORM_BITS  = 31;
    localparam int ROOT_BITS  = 32;
    localparam int DEPTH_BITS = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd3;

    localparam logic [CFG_W-1:0] FOCAL_X_RST  = 32'd33554432;
    localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 32'd33554432;
    localparam logic [CFG_W-1:0] CENTER_X_RST = 32'd20971520;
    localparam logic [CFG_W-1:0] CENTER_Y_RST = 32'd15728640;

    localparam logic [NORM_BITS-1:0] COORD_SAT = 31'h7FFF_FFFF;

endpackage
`default_nettype wire

### design/rdpd_div_cell.sv
`default_nettype none
module rdpd_div_cell #(
    parameter int DW = 32,
    parameter int NB = 32,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          v_in,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [DW-1:0] dvs_in,
    input  wire logic [NB-1:0] bits_in,
    input  wire logic [NB-1:0] quo_in,
    input  wire logic [SW-1:0] side_in,
    output logic               v_out,
    output logic [DW-1:0]      rem_out,
    output logic [DW-1:0]      dvs_out,
    output logic [NB-1:0]      bits_out,
    output logic [NB-1:0]      quo_out,
    output logic [SW-1:0]      side_out
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic          v_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg;
    logic [NB-1:0] bits_reg, bits_next;
    logic [NB-1:0] quo_reg, quo_next;
    logic [SW-1:0] side_reg;

    always_comb
    begin
        trial     = {rem_in, bits_in[NB-1]};
        diff      = trial - {1'b0, dvs_in};
        ge        = (trial >= {1'b0, dvs_in});
        rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
        bits_next = {bits_in[NB-2:0], 1'b0};
        quo_next  = {quo_in[NB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_in;
        bits_reg <= bits_next;
        quo_reg  <= quo_next;
        side_reg <= side_in;
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign dvs_out  = dvs_reg;
    assign bits_out = bits_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

### design/rdpd_root_cell.sv
`default_nettype none
module rdpd_root_cell #(
    parameter int SW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          v_in,
    input  wire logic [34:0]   rem_in,
    input  wire logic [31:0]   root_in,
    input  wire logic [63:0]   bits_in,
    input  wire logic [SW-1:0] side_in,
    output logic               v_out,
    output logic [34:0]        rem_out,
    output logic [31:0]        root_out,
    output logic [63:0]        bits_out,
    output logic [SW-1:0]      side_out
);

    logic [34:0]   acc;
    logic [34:0]   trial;
    logic          ge;
    logic          v_reg;
    logic [34:0]   rem_reg, rem_next;
    logic [31:0]   root_reg, root_next;
    logic [63:0]   bits_reg, bits_next;
    logic [SW-1:0] side_reg;

    always_comb
    begin
        acc       = {rem_in[32:0], bits_in[63:62]};
        trial     = {1'b0, root_in, 2'b01};
        ge        = (acc >= trial);
        rem_next  = ge ? (acc - trial) : acc;
        root_next = {root_in[30:0], ge};
        bits_next = {bits_in[61:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bits_reg <= bits_next;
        side_reg <= side_in;
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign bits_out = bits_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

### design/ray_distance_to_planar_depth.sv
// Channel   Signals                                   Handshake
// config    cfg_we, cfg_index, cfg_data               write when cfg_we high
// input     start, busy, pixel_col, pixel_row,        item taken on start & !busy
//           ray_distance
// result    done, axial_depth                         done strobe per item
//
// One item per cycle; stages in order: input stage, 31 normalize cells,
// square stage, sum stage, 32 square-root cells, 32 divide cells.
// busy stays low; every cell moves its item forward in every cycle.
// Reset clears the valid flags and loads the register defaults.
// The receiver cannot stall; the result is shown for one cycle only.
`default_nettype none
module ray_distance_to_planar_depth #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rdpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rdpd_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [rdpd_pkg::COORD_W-1:0]       pixel_col,
    input  wire logic [rdpd_pkg::COORD_W-1:0]       pixel_row,
    input  wire logic [31:0]                        ray_distance,
    output logic                                    done,
    output logic [31:0]                             axial_depth
);

    localparam int NB = rdpd_pkg::NORM_BITS;
    localparam int RB = rdpd_pkg::ROOT_BITS;
    localparam int DB = rdpd_pkg::DEPTH_BITS;

    logic [31:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;

    logic [11:0] col_c, row_c;
    logic [31:0] mx_next, my_next;
    logic [32:0] px, py;

    logic        v0_reg;
    logic [31:0] mx_reg, my_reg, fx_reg, fy_reg, dist0_reg;
    logic        satx, saty;

    logic [NB:0]           nv;
    logic [NB:0][31:0]     rx, ry, dx, dy;
    logic [NB:0][NB-1:0]   bx, by, qx, qy;
    logic [NB:0][32:0]     sx;
    logic [NB:0][0:0]      sy;
    logic [NB-1:0]         vy;

    logic [NB-1:0] ax, ay;
    logic          v1_reg;
    logic [61:0]   sqx_reg, sqy_reg;
    logic [31:0]   dist1_reg;
    logic          v2_reg;
    logic [63:0]   s_reg;
    logic [31:0]   dist2_reg;

    logic [RB:0]           rv;
    logic [RB:0][34:0]     rr;
    logic [RB:0][31:0]     rt;
    logic [RB:0][63:0]     rbits;
    logic [RB:0][31:0]     rside;

    logic [DB:0]           fv;
    logic [DB:0][31:0]     fr, fd;
    logic [DB:0][DB-1:0]   fb, fq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= rdpd_pkg::FOCAL_X_RST;
            focal_y_reg  <= rdpd_pkg::FOCAL_Y_RST;
            center_x_reg <= rdpd_pkg::CENTER_X_RST;
            center_y_reg <= rdpd_pkg::CENTER_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rdpd_pkg::REG_FOCAL_X:  focal_x_reg  <= cfg_data;
                rdpd_pkg::REG_FOCAL_Y:  focal_y_reg  <= cfg_data;
                rdpd_pkg::REG_CENTER_X: center_x_reg <= cfg_data;
                rdpd_pkg::REG_CENTER_Y: center_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    always_comb
    begin
        col_c = ({5'b0, pixel_col} > 17'(MAX_WIDTH - 1))  ? 12'(MAX_WIDTH - 1)  : pixel_col;
        row_c = ({5'b0, pixel_row} > 17'(MAX_HEIGHT - 1)) ? 12'(MAX_HEIGHT - 1) : pixel_row;
        px = {5'b0, col_c, 16'b0};
        py = {5'b0, row_c, 16'b0};
        mx_next = (px >= {1'b0, center_x_reg}) ? 32'(px - {1'b0, center_x_reg})
                                               : 32'({1'b0, center_x_reg} - px);
        my_next = (py >= {1'b0, center_y_reg}) ? 32'(py - {1'b0, center_y_reg})
                                               : 32'({1'b0, center_y_reg} - py);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start & ~busy;
            v1_reg <= nv[NB];
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        fx_reg    <= (focal_x_reg == 32'd0) ? 32'd1 : focal_x_reg;
        fy_reg    <= (focal_y_reg == 32'd0) ? 32'd1 : focal_y_reg;
        dist0_reg <= ray_distance;
    end

    assign satx = ({15'b0, mx_reg} >= {fx_reg, 15'b0});
    assign saty = ({15'b0, my_reg} >= {fy_reg, 15'b0});

    assign nv[0]    = v0_reg;
    assign rx[0]    = {15'b0, mx_reg[31:15]};
    assign ry[0]    = {15'b0, my_reg[31:15]};
    assign dx[0]    = fx_reg;
    assign dy[0]    = fy_reg;
    assign bx[0]    = {mx_reg[14:0], 16'b0};
    assign by[0]    = {my_reg[14:0], 16'b0};
    assign qx[0]    = '0;
    assign qy[0]    = '0;
    assign sx[0]    = {satx, dist0_reg};
    assign sy[0]    = saty;

    for (genvar i = 0; i < NB; i++)
    begin : g_norm
        rdpd_div_cell #(.DW(32), .NB(NB), .SW(33)) u_x (
            .clk(clk), .rst_n(rst_n), .v_in(nv[i]),
            .rem_in(rx[i]), .dvs_in(dx[i]), .bits_in(bx[i]), .quo_in(qx[i]),
            .side_in(sx[i]),
            .v_out(nv[i+1]), .rem_out(rx[i+1]), .dvs_out(dx[i+1]),
            .bits_out(bx[i+1]), .quo_out(qx[i+1]), .side_out(sx[i+1])
        );
        rdpd_div_cell #(.DW(32), .NB(NB), .SW(1)) u_y (
            .clk(clk), .rst_n(rst_n), .v_in(nv[i]),
            .rem_in(ry[i]), .dvs_in(dy[i]), .bits_in(by[i]), .quo_in(qy[i]),
            .side_in(sy[i]),
            .v_out(vy[i]), .rem_out(ry[i+1]), .dvs_out(dy[i+1]),
            .bits_out(by[i+1]), .quo_out(qy[i+1]), .side_out(sy[i+1])
        );
    end

    assign ax = sx[NB][32] ? rdpd_pkg::COORD_SAT : qx[NB];
    assign ay = sy[NB][0]  ? rdpd_pkg::COORD_SAT : qy[NB];

    always_ff @(posedge clk)
    begin
        sqx_reg   <= ax * ax;
        sqy_reg   <= ay * ay;
        dist1_reg <= sx[NB][31:0];
        s_reg     <= {2'b0, sqx_reg} + {2'b0, sqy_reg} + 64'h1_0000_0000;
        dist2_reg <= dist1_reg;
    end

    assign rv[0]    = v2_reg;
    assign rr[0]    = '0;
    assign rt[0]    = '0;
    assign rbits[0] = s_reg;
    assign rside[0] = dist2_reg;

    for (genvar j = 0; j < RB; j++)
    begin : g_root
        rdpd_root_cell #(.SW(32)) u_root (
            .clk(clk), .rst_n(rst_n), .v_in(rv[j]),
            .rem_in(rr[j]), .root_in(rt[j]), .bits_in(rbits[j]), .side_in(rside[j]),
            .v_out(rv[j+1]), .rem_out(rr[j+1]), .root_out(rt[j+1]),
            .bits_out(rbits[j+1]), .side_out(rside[j+1])
        );
    end

    assign fv[0] = rv[RB] & ~vy[NB-1] | rv[RB];
    assign fr[0] = {16'b0, rside[RB][31:16]};
    assign fd[0] = rt[RB];
    assign fb[0] = {rside[RB][15:0], 16'b0};
    assign fq[0] = '0;

    for (genvar k = 0; k < DB; k++)
    begin : g_depth
        rdpd_div_cell #(.DW(32), .NB(DB), .SW(1)) u_div (
            .clk(clk), .rst_n(rst_n), .v_in(fv[k]),
            .rem_in(fr[k]), .dvs_in(fd[k]), .bits_in(fb[k]), .quo_in(fq[k]),
            .side_in(1'b0),
            .v_out(fv[k+1]), .rem_out(fr[k+1]), .dvs_out(fd[k+1]),
            .bits_out(fb[k+1]), .quo_out(fq[k+1]), .side_out()
        );
    end

    assign done        = fv[DB];
    assign axial_depth = fq[DB];

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int LATENCY = 98;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 1500;
    localparam logic [rdpd_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd4;
    localparam logic [rdpd_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 8'hFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [rdpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rdpd_pkg::CFG_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic [rdpd_pkg::COORD_W-1:0] pixel_col = '0;
    logic [rdpd_pkg::COORD_W-1:0] pixel_row = '0;
    logic [31:0] ray_distance = '0;
    logic done;
    logic [31:0] axial_depth;

    logic [31:0] fx, fy, cx, cy;
    logic [31:0] depth_q[$];
    int errors = 0;
    int cycles = 0;

    typedef struct {
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] ray_len;
        bit known;
        logic [31:0] depth;
    } pixel_row_t;

    ray_distance_to_planar_depth dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .pixel_col(pixel_col),
        .pixel_row(pixel_row), .ray_distance(ray_distance), .done(done),
        .axial_depth(axial_depth)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("ray_distance_to_planar_depth: mismatch");
            $finish;
        end
    end

    function automatic logic [63:0] norm_mag(logic [11:0] pix, logic [31:0] ctr,
                                             logic [31:0] foc);
        logic [63:0] p, m, f, q;
        p = {36'd0, pix, 16'd0};
        m = (p >= {32'd0, ctr}) ? p - ctr : {32'd0, ctr} - p;
        f = (foc == 0) ? 64'd1 : {32'd0, foc};
        q = (m << 16) / f;
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] planar_depth(logic [11:0] col, logic [11:0] row,
                                                 logic [31:0] ray_len);
        logic [63:0] ax, ay, s, d, n;
        ax = norm_mag(col, cx, fx);
        ay = norm_mag(row, cy, fy);
        s = ax * ax + ay * ay + (64'd1 << 32);
        d = isqrt(s);
        if (d == 0)
            d = 1;
        n = {16'd0, ray_len, 16'd0};
        return 32'(n / d);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("error: %s got %h want %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (depth_q.size() == 0)
                report("unexpected item", axial_depth, 32'h0);
            else
            begin
                logic [31:0] want;
                want = depth_q.pop_front();
                if (axial_depth !== want)
                    report("axial_depth", axial_depth, want);
            end
        end
    end

    task automatic write_reg(input logic [rdpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            rdpd_pkg::REG_FOCAL_X: fx = val;
            rdpd_pkg::REG_FOCAL_Y: fy = val;
            rdpd_pkg::REG_CENTER_X: cx = val;
            rdpd_pkg::REG_CENTER_Y: cy = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (depth_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send(input logic [11:0] col, input logic [11:0] row,
                        input logic [31:0] ray_len, input bit gaps, input bit known,
                        input logic [31:0] want);
        while (gaps && $urandom_range(99) < 15)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        ray_distance <= ray_len;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        depth_q.insert(depth_q.size(), known ? want : planar_depth(col, row, ray_len));
    endtask

    task automatic random_phase(input int n, input bit gaps);
        for (int i = 0; i < n; i++)
            send(12'($urandom), 12'($urandom), $urandom, gaps, 1'b0, 32'h0);
        start <= 1'b0;
        drain();
    endtask

    pixel_row_t directed[10] = '{
        '{12'd320, 12'd240, 32'h0001_0000, 1, 32'h0001_0000},
        '{12'd320, 12'd240, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF},
        '{12'd320, 12'd240, 32'h0, 1, 32'h0},
        '{12'd0, 12'd0, 32'hFFFF_FFFF, 0, 32'h0},
        '{12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 0, 32'h0},
        '{12'hFFF, 12'd0, 32'h1234_5678, 0, 32'h0},
        '{12'd0, 12'hFFF, 32'h8000_0000, 0, 32'h0},
        '{12'd832, 12'd240, 32'h0001_0000, 0, 32'h0},
        '{12'hAAA, 12'h555, 32'hAAAA_5555, 0, 32'h0},
        '{12'h555, 12'hAAA, 32'h5555_AAAA, 0, 32'h0}
    };

    initial
    begin
        fx = rdpd_pkg::FOCAL_X_RST;
        fy = rdpd_pkg::FOCAL_Y_RST;
        cx = rdpd_pkg::CENTER_X_RST;
        cy = rdpd_pkg::CENTER_Y_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send(directed[i].col, directed[i].row, directed[i].ray_len, 1'b0,
                 directed[i].known, directed[i].depth);
        start <= 1'b0;
        drain();

        write_reg(rdpd_pkg::REG_FOCAL_X, 32'h0);
        write_reg(rdpd_pkg::REG_FOCAL_Y, 32'h0);
        write_reg(rdpd_pkg::REG_CENTER_X, 32'h0);
        write_reg(rdpd_pkg::REG_CENTER_Y, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_LAST, 32'h0);
        send(12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);
        send(12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);
        random_phase(40, 1'b1);

        write_reg(rdpd_pkg::REG_FOCAL_X, 32'hFFFF_FFFF);
        write_reg(rdpd_pkg::REG_FOCAL_Y, 32'hFFFF_FFFF);
        write_reg(rdpd_pkg::REG_CENTER_X, 32'hFFFF_FFFF);
        write_reg(rdpd_pkg::REG_CENTER_Y, 32'h0);
        write_reg(REG_SPARE_FIRST, 32'h1);
        random_phase(60, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(rdpd_pkg::REG_FOCAL_X, ph[0] ? $urandom : {8'h0, 24'($urandom)});
            write_reg(rdpd_pkg::REG_FOCAL_Y, ph[1] ? $urandom : {8'h0, 24'($urandom)});
            write_reg(rdpd_pkg::REG_CENTER_X, ph[0] ? $urandom : {4'h0, 28'($urandom)});
            write_reg(rdpd_pkg::REG_CENTER_Y, ph[2] ? $urandom : {4'h0, 28'($urandom)});
            random_phase(RANDOM_ITEMS / 6, ph != 3);
        end

        if (errors == 0)
            $display("ray_distance_to_planar_depth: match");
        else
            $display("ray_distance_to_planar_depth: mismatch");
        $finish;
    end
endmodule
